[rtl/core/odpi_pkg.sv]
// Shared types, constants and channel math for the ordered dither palette indexer.
package odpi_pkg;

  localparam int MATRIX_SIZE    = 8;
  localparam int MAX_LINE_WIDTH = 4096;
  localparam int IDX_SCALE      = MATRIX_SIZE * MATRIX_SIZE + 1;
  localparam int CFG_IDX_W      = 2;
  localparam int SHADE_W        = 9;
  localparam int POS_W          = $clog2(MAX_LINE_WIDTH);
  localparam int WIDTH_W        = POS_W + 1;

  localparam logic [CFG_IDX_W-1:0] REG_RED   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GRAY  = 2'd3;

  localparam logic [SHADE_W-1:0] RED_RESET   = 9'd8;
  localparam logic [SHADE_W-1:0] GREEN_RESET = 9'd8;
  localparam logic [SHADE_W-1:0] BLUE_RESET  = 9'd4;
  localparam logic [SHADE_W-1:0] GRAY_RESET  = 9'd2;

  localparam logic OP_COLOR = 1'b0;
  localparam logic OP_GRAY  = 1'b1;

  localparam logic [5:0] BAYER8 [8][8] = '{
    '{6'd0,  6'd32, 6'd8,  6'd40, 6'd2,  6'd34, 6'd10, 6'd42},
    '{6'd48, 6'd16, 6'd56, 6'd24, 6'd50, 6'd18, 6'd58, 6'd26},
    '{6'd12, 6'd44, 6'd4,  6'd36, 6'd14, 6'd46, 6'd6,  6'd38},
    '{6'd60, 6'd28, 6'd52, 6'd20, 6'd62, 6'd30, 6'd54, 6'd22},
    '{6'd3,  6'd35, 6'd11, 6'd43, 6'd1,  6'd33, 6'd9,  6'd41},
    '{6'd51, 6'd19, 6'd59, 6'd27, 6'd49, 6'd17, 6'd57, 6'd25},
    '{6'd15, 6'd47, 6'd7,  6'd39, 6'd13, 6'd45, 6'd5,  6'd37},
    '{6'd63, 6'd31, 6'd55, 6'd23, 6'd61, 6'd29, 6'd53, 6'd21}
  };

  localparam logic [5:0] BAYER4 [4][4] = '{
    '{6'd0,  6'd8,  6'd2,  6'd10},
    '{6'd12, 6'd4,  6'd14, 6'd6},
    '{6'd3,  6'd11, 6'd1,  6'd9},
    '{6'd15, 6'd7,  6'd13, 6'd5}
  };

  typedef struct packed {
    logic                 op;
    logic [7:0]           red_in;
    logic [7:0]           green_in;
    logic [7:0]           blue_in;
    logic [7:0]           gray_in;
    logic [15:0]          row;
    logic [POS_W-1:0]     position;
    logic [WIDTH_W-1:0]   line_width;
    logic                 mirror;
  } pixel_t;

  typedef struct packed {
    logic [7:0]       palette_index;
    logic [POS_W-1:0] dest_position;
  } result_t;

  typedef struct packed {
    logic [SHADE_W-1:0] red;
    logic [SHADE_W-1:0] green;
    logic [SHADE_W-1:0] blue;
    logic [SHADE_W-1:0] gray;
    logic [7:0]         gm;
    logic [7:0]         bm;
  } cfg_t;

  // One channel after classification: low shade (mod 256) and matrix compare.
  typedef struct packed {
    logic [7:0] low8;
    logic       lt;
    logic       eq;
  } chan_t;

  typedef struct packed {
    logic             op;
    chan_t            ch_r;
    chan_t            ch_g;
    chan_t            ch_b;
    logic [POS_W-1:0] dest;
  } mid_t;

  function automatic logic [5:0] matrix_entry(input logic [2:0] r, input logic [2:0] c);
    logic [5:0] e;
    if (MATRIX_SIZE == 8) begin
      e = BAYER8[r][c];
    end else begin
      e = BAYER4[r[1:0]][c[1:0]];
    end
    return e;
  endfunction

  // Split a channel value into low shade and fraction, compare with matrix entry.
  function automatic chan_t chan_split(input logic [7:0] v, input logic [SHADE_W-1:0] s,
                                       input logic [5:0] e);
    logic [SHADE_W-1:0] sm1;
    logic [16:0]        p;
    logic [14:0]        fprod;
    logic [6:0]         idx;
    chan_t              c;
    sm1   = SHADE_W'(s - 9'd1);
    p     = 17'(v) * 17'(sm1);
    fprod = 15'(p[7:0]) * 15'(IDX_SCALE);
    idx   = fprod[14:8];
    c.low8 = p[15:8];
    c.lt   = (7'(e) < idx);
    c.eq   = (7'(e) == idx);
    return c;
  endfunction

  // Scale low and high shades and pick one.
  function automatic logic [7:0] chan_pick(input chan_t c, input logic [7:0] m);
    logic [15:0] lo_prod;
    logic [15:0] hi_prod;
    logic [7:0]  hi1;
    logic [7:0]  lo8;
    logic [7:0]  hi8;
    hi1     = c.low8 + 8'd1;
    lo_prod = 16'(c.low8) * 16'(m);
    hi_prod = 16'(hi1) * 16'(m);
    lo8     = lo_prod[7:0];
    hi8     = hi_prod[7:0];
    return (c.lt || (c.eq && ((lo8 | hi8) != 8'd0))) ? hi8 : lo8;
  endfunction

endpackage

[rtl/core/odpi_cfg.sv]
// Shade count registers and derived channel multipliers.
module odpi_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [odpi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [odpi_pkg::SHADE_W-1:0]    cfg_data,
  output odpi_pkg::cfg_t                  cfg
);
  import odpi_pkg::*;

  logic [SHADE_W-1:0] red;
  logic [SHADE_W-1:0] green;
  logic [SHADE_W-1:0] blue;
  logic [SHADE_W-1:0] gray;
  logic [7:0]         gm;
  logic [15:0]        gm_prod;

  assign cfg_ready = 1'b1;
  assign gm_prod   = 16'(green[7:0]) * 16'(blue[7:0]);

  // Take register writes; refresh the red multiplier every cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      red   <= RED_RESET;
      green <= GREEN_RESET;
      blue  <= BLUE_RESET;
      gray  <= GRAY_RESET;
      gm    <= 8'd0;
    end else begin
      gm <= gm_prod[7:0];
      if (cfg_valid) begin
        case (cfg_index)
          REG_RED:   red   <= cfg_data;
          REG_GREEN: green <= cfg_data;
          REG_BLUE:  blue  <= cfg_data;
          REG_GRAY:  gray  <= cfg_data;
          default:   red   <= red;
        endcase
      end
    end
  end

  always_comb begin
    cfg.red   = red;
    cfg.green = green;
    cfg.blue  = blue;
    cfg.gray  = gray;
    cfg.gm    = gm;
    cfg.bm    = blue[7:0];
  end

endmodule

[rtl/core/odpi_front.sv]
// Front end: accept pixels, pick the matrix entry, classify each channel.
module odpi_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  odpi_pkg::pixel_t  pixel,
  input  odpi_pkg::cfg_t    cfg,
  output logic              q_push,
  input  logic              q_ready,
  output odpi_pkg::mid_t    q_data
);
  import odpi_pkg::*;

  logic             vld;
  mid_t             stage;
  mid_t             stage_next;
  logic             accept;
  logic [POS_W-1:0] rev;
  logic [5:0]       e;
  logic [7:0]       slot_b;
  logic [SHADE_W-1:0] slot_b_shades;

  assign full   = vld && !q_ready;
  assign accept = push && !full;
  assign q_push = vld;
  assign q_data = stage;

  // Classify the incoming pixel; gray uses the third slot with unit multiplier
  always_comb begin
    rev           = POS_W'(pixel.line_width - WIDTH_W'(1) - WIDTH_W'(pixel.position));
    e             = matrix_entry(pixel.row[2:0], rev[2:0]);
    slot_b        = (pixel.op == OP_GRAY) ? pixel.gray_in : pixel.blue_in;
    slot_b_shades = (pixel.op == OP_GRAY) ? cfg.gray : cfg.blue;
    stage_next.op   = pixel.op;
    stage_next.ch_r = chan_split(pixel.red_in, cfg.red, e);
    stage_next.ch_g = chan_split(pixel.green_in, cfg.green, e);
    stage_next.ch_b = chan_split(slot_b, slot_b_shades, e);
    stage_next.dest = (pixel.op == OP_COLOR && pixel.mirror) ? rev : pixel.position;
  end

  // Hold the stage until the queue takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (accept) begin
      vld <= 1'b1;
    end else if (q_ready) begin
      vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage <= stage_next;
    end
  end

endmodule

[rtl/core/odpi_xfer_q.sv]
// Two-entry queue between the front end and the back end.
module odpi_xfer_q (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  output logic            wr_ready,
  input  odpi_pkg::mid_t  wr_data,
  output logic            rd_valid,
  input  logic            rd_en,
  output odpi_pkg::mid_t  rd_data
);
  import odpi_pkg::*;

  mid_t       mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       do_wr;
  logic       do_rd;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_data  = mem[rptr];
  assign do_wr    = wr_en && wr_ready;
  assign do_rd    = rd_en && rd_valid;

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_wr) wptr <= !wptr;
      if (do_rd) rptr <= !rptr;
      count <= count + 2'(do_wr) - 2'(do_rd);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wr_data;
    end
  end

endmodule

[rtl/core/odpi_back.sv]
// Back end: scale shades, sum channels, and queue results for the consumer.
module odpi_back (
  input  logic               clk,
  input  logic               rst,
  input  odpi_pkg::cfg_t     cfg,
  input  logic               q_valid,
  output logic               q_pop,
  input  odpi_pkg::mid_t     q_data,
  output logic               empty,
  input  logic               pop,
  output odpi_pkg::result_t  result
);
  import odpi_pkg::*;

  result_t    omem [2];
  logic       owptr;
  logic       orptr;
  logic [1:0] ocount;
  logic       ofull;
  logic       do_pop;
  result_t    res_next;
  logic [7:0] sum_r;
  logic [7:0] sum_g;
  logic [7:0] sum_b;

  assign ofull  = (ocount == 2'd2);
  assign empty  = (ocount == 2'd0);
  assign q_pop  = q_valid && !ofull;
  assign do_pop = pop && !empty;
  assign result = omem[orptr];

  // Build the palette index from the classified channels
  always_comb begin
    sum_r = chan_pick(q_data.ch_r, cfg.gm);
    sum_g = chan_pick(q_data.ch_g, cfg.bm);
    sum_b = chan_pick(q_data.ch_b, 8'd1);
    if (q_data.op == OP_GRAY) begin
      res_next.palette_index = sum_b;
    end else begin
      res_next.palette_index = sum_r + sum_g + sum_b;
    end
    res_next.dest_position = q_data.dest;
  end

  // Advance the result queue
  always_ff @(posedge clk) begin
    if (rst) begin
      owptr  <= 1'b0;
      orptr  <= 1'b0;
      ocount <= 2'd0;
    end else begin
      if (q_pop)  owptr <= !owptr;
      if (do_pop) orptr <= !orptr;
      ocount <= ocount + 2'(q_pop) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      omem[owptr] <= res_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) ocount <= 2'd2)
    else $error("result queue overflow");

  a_pop_drains: assert property (@(posedge clk) disable iff (rst)
    (do_pop && !q_pop) |=> (ocount == $past(ocount) - 2'd1))
    else $error("result queue did not drain on pop");

  a_take_fills: assert property (@(posedge clk) disable iff (rst)
    (q_pop && !do_pop) |=> (ocount == $past(ocount) + 2'd1))
    else $error("result queue did not fill on take");

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

endmodule

[rtl/core/ordered_dither_palette_index.sv]
// Top level of the ordered dither palette indexer.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-----------------------------------
//   pixel    | push / full          | pixel (op, bytes, row, pos, width)
//   result   | pop / empty          | result (palette_index, dest_position)
//   config   | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One pixel is accepted per clock while full is low; its result passes through the
// front stage, the transfer queue and the result queue, and can then be popped;
// one result leaves per clock while empty is low.
// The front end stalls only when its stage and the two-entry transfer queue
// are full; the back end stalls only when the two-entry result queue is full.
// Synchronous reset empties both queues and loads the default shade counts.
module ordered_dither_palette_index (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  odpi_pkg::pixel_t                pixel,
  output logic                            empty,
  input  logic                            pop,
  output odpi_pkg::result_t               result,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [odpi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [odpi_pkg::SHADE_W-1:0]    cfg_data
);
  import odpi_pkg::*;

  cfg_t cfg;
  logic f_push;
  logic f_ready;
  mid_t f_data;
  logic b_valid;
  logic b_pop;
  mid_t b_data;

  odpi_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  odpi_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .pixel   (pixel),
    .cfg     (cfg),
    .q_push  (f_push),
    .q_ready (f_ready),
    .q_data  (f_data)
  );

  odpi_xfer_q u_xfer_q (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (f_push),
    .wr_ready (f_ready),
    .wr_data  (f_data),
    .rd_valid (b_valid),
    .rd_en    (b_pop),
    .rd_data  (b_data)
  );

  odpi_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (b_valid),
    .q_pop   (b_pop),
    .q_data  (b_data),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule
